>>> rtl/sgr_pkg.sv
package sgr_pkg;

	// colour modes
	localparam logic [1:0] MODE_UNCHANGED = 2'd0;
	localparam logic [1:0] MODE_DEFAULT   = 2'd1;
	localparam logic [1:0] MODE_INDEXED   = 2'd2;
	localparam logic [1:0] MODE_RGB       = 2'd3;

	// on/off attribute modes
	localparam logic [1:0] FLAG_UNCHANGED = 2'd0;
	localparam logic [1:0] FLAG_OFF       = 2'd1;
	localparam logic [1:0] FLAG_ON        = 2'd2;

	// extended colour phases
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_TYPE  = 3'd1;
	localparam logic [2:0] PH_RED   = 3'd2;
	localparam logic [2:0] PH_GREEN = 3'd3;
	localparam logic [2:0] PH_BLUE  = 3'd4;
	localparam logic [2:0] PH_INDEX = 3'd5;

	// sgr codes
	localparam logic [31:0] SGR_RESET       = 32'd0;
	localparam logic [31:0] SGR_BOLD_ON     = 32'd1;
	localparam logic [31:0] SGR_FAINT       = 32'd2;
	localparam logic [31:0] SGR_UNDER_ON    = 32'd4;
	localparam logic [31:0] SGR_REVERSE_ON  = 32'd7;
	localparam logic [31:0] SGR_BOLD_OFF    = 32'd22;
	localparam logic [31:0] SGR_UNDER_OFF   = 32'd24;
	localparam logic [31:0] SGR_REVERSE_OFF = 32'd27;
	localparam logic [31:0] SGR_FG_BASE     = 32'd30;
	localparam logic [31:0] SGR_FG_LAST     = 32'd37;
	localparam logic [31:0] SGR_FG_EXT      = 32'd38;
	localparam logic [31:0] SGR_FG_DEFAULT  = 32'd39;
	localparam logic [31:0] SGR_BG_BASE     = 32'd40;
	localparam logic [31:0] SGR_BG_LAST     = 32'd47;
	localparam logic [31:0] SGR_BG_EXT      = 32'd48;
	localparam logic [31:0] SGR_BG_DEFAULT  = 32'd49;
	localparam logic [31:0] SGR_FG_BRIGHT   = 32'd90;
	localparam logic [31:0] SGR_FG_BR_LAST  = 32'd97;
	localparam logic [31:0] SGR_BG_BRIGHT   = 32'd100;
	localparam logic [31:0] SGR_BG_BR_LAST  = 32'd107;

	// extended colour types
	localparam logic [31:0] EXT_TYPE_RGB     = 32'd2;
	localparam logic [31:0] EXT_TYPE_PALETTE = 32'd5;

	// palette layout
	localparam logic [7:0] PAL_CUBE_FIRST = 8'd16;
	localparam logic [7:0] PAL_GREY_FIRST = 8'd232;
	localparam logic [7:0] GREY_BASE      = 8'h08;
	localparam logic [7:0] GREY_STEP      = 8'd10;
	// 171/1024 stands in for 1/6 over the cube range
	localparam logic [7:0] RECIP_SIX      = 8'd171;
	localparam int         RECIP_SHIFT    = 10;

	typedef struct packed {
		logic [31:0] param_value;
		logic        is_last;
		logic        empty_list;
	} sgr_in_t;

	typedef struct packed {
		logic [1:0]  fg_mode;
		logic [23:0] fg_value;
		logic [1:0]  bg_mode;
		logic [23:0] bg_value;
		logic [1:0]  bold_mode;
		logic [1:0]  underline_mode;
		logic [1:0]  reverse_mode;
	} sgr_out_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [23:0] value;
	} colour_t;

	localparam sgr_out_t ATTR_DEFAULTS = '{
		fg_mode: MODE_DEFAULT, fg_value: 24'd0,
		bg_mode: MODE_DEFAULT, bg_value: 24'd0,
		bold_mode: FLAG_OFF, underline_mode: FLAG_OFF, reverse_mode: FLAG_OFF
	};

	function automatic logic [7:0] cube_level(input logic [2:0] step);
		case (step)
			3'd0:    cube_level = 8'h00;
			3'd1:    cube_level = 8'h5f;
			3'd2:    cube_level = 8'h87;
			3'd3:    cube_level = 8'haf;
			3'd4:    cube_level = 8'hd7;
			default: cube_level = 8'hff;
		endcase
	endfunction

	// xterm-256 index to base index, cube colour or grey
	function automatic colour_t palette_colour(input logic [7:0] idx);
		logic [7:0]  k;
		logic [15:0] prod6;
		logic [5:0]  q6;
		logic [13:0] prod36;
		logic [2:0]  q36;
		logic [7:0]  b_step;
		logic [5:0]  g_step;
		logic [7:0]  grey;
		colour_t     res;
		k      = idx - PAL_CUBE_FIRST;
		prod6  = 16'(k) * 16'(RECIP_SIX);
		q6     = prod6[RECIP_SHIFT +: 6];
		prod36 = 14'(q6) * 14'(RECIP_SIX);
		q36    = prod36[RECIP_SHIFT +: 3];
		b_step = k - ({2'b00, q6} * 8'd6);
		g_step = q6 - ({3'b000, q36} * 6'd6);
		grey   = GREY_BASE + 8'((idx - PAL_GREY_FIRST) * GREY_STEP);
		if (idx < PAL_CUBE_FIRST) begin
			res.mode  = MODE_INDEXED;
			res.value = {16'd0, idx};
		end else if (idx >= PAL_GREY_FIRST) begin
			res.mode  = MODE_RGB;
			res.value = {grey, grey, grey};
		end else begin
			res.mode  = MODE_RGB;
			res.value = {cube_level(q36), cube_level(g_step[2:0]), cube_level(b_step[2:0])};
		end
		return res;
	endfunction

endpackage

>>> rtl/sgr_attribute_interpreter_top.sv
// channel   | valid      | ready      | payload            | item
// ----------+------------+------------+--------------------+-------------------------------
// input     | param_valid| param_ready| param (sgr_in_t)   | one sgr parameter of a sequence
// output    | attr_valid | attr_ready | attr (sgr_out_t)   | gathered attribute change
//
// an item is registered on entry, decoded in the following cycle and, when it
// ends a sequence, lands in the output register: one item per cycle sustained
// unless a held result stalls an item that ends a sequence.
// the accumulator is updated as an item leaves the input register.
// a held result stalls only an item that would itself give a result; items
// that only gather go on flowing. reset empties both registers and clears the
// accumulator to all unchanged.
module sgr_attribute_interpreter_top
	import sgr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     param_valid,
	output logic     param_ready,
	input  sgr_in_t  param,
	output logic     attr_valid,
	input  logic     attr_ready,
	output sgr_out_t attr
);

	// accumulated change for the sequence in flight
	typedef struct packed {
		colour_t    fg;
		colour_t    bg;
		logic [1:0] bold;
		logic [1:0] underline;
		logic [1:0] reverse;
		logic [2:0] phase;
		logic       is_fg;
		logic [15:0] rg;
	} acc_t;

	logic     valid_s1;
	sgr_in_t  item_s1;
	acc_t     acc_q;
	acc_t     acc_nxt;
	logic     out_valid_q;
	sgr_out_t out_q;

	logic     emit;
	logic     out_free;
	logic     advance;
	sgr_out_t result;
	colour_t  pal;
	colour_t  new_col;
	logic     set_col;
	logic     set_fg;
	logic [31:0] p;

	assign p        = item_s1.param_value;
	assign emit     = item_s1.empty_list | item_s1.is_last;
	assign out_free = ~out_valid_q | attr_ready;
	// a gathering item always moves on; an ending item waits for the output slot
	assign advance  = valid_s1 & (~emit | out_free);
	assign param_ready = ~valid_s1 | advance;

	// decode of one parameter against the accumulator
	always_comb begin
		acc_nxt = acc_q;
		pal     = palette_colour(p[7:0]);
		new_col = '0;
		set_col = 1'b0;
		set_fg  = acc_q.is_fg;
		case (acc_q.phase)
			PH_TYPE: begin
				if (p == EXT_TYPE_RGB) begin
					acc_nxt.phase = PH_RED;
				end else if (p == EXT_TYPE_PALETTE) begin
					acc_nxt.phase = PH_INDEX;
				end else begin
					acc_nxt.phase = PH_IDLE;
				end
			end
			PH_RED: begin
				acc_nxt.rg    = {p[7:0], 8'h00};
				acc_nxt.phase = PH_GREEN;
			end
			PH_GREEN: begin
				acc_nxt.rg    = {acc_q.rg[15:8], p[7:0]};
				acc_nxt.phase = PH_BLUE;
			end
			PH_BLUE: begin
				new_col       = '{mode: MODE_RGB, value: {acc_q.rg, p[7:0]}};
				set_col       = 1'b1;
				acc_nxt.phase = PH_IDLE;
			end
			PH_INDEX: begin
				new_col       = pal;
				set_col       = 1'b1;
				acc_nxt.phase = PH_IDLE;
			end
			default: begin
				acc_nxt.phase = PH_IDLE;
				if (p == SGR_RESET) begin
					acc_nxt.fg        = '{mode: MODE_DEFAULT, value: 24'd0};
					acc_nxt.bg        = '{mode: MODE_DEFAULT, value: 24'd0};
					acc_nxt.bold      = FLAG_OFF;
					acc_nxt.underline = FLAG_OFF;
					acc_nxt.reverse   = FLAG_OFF;
				end else if (p == SGR_FG_DEFAULT) begin
					acc_nxt.fg = '{mode: MODE_DEFAULT, value: 24'd0};
				end else if (p == SGR_BG_DEFAULT) begin
					acc_nxt.bg = '{mode: MODE_DEFAULT, value: 24'd0};
				end else if (p == SGR_BOLD_ON) begin
					acc_nxt.bold = FLAG_ON;
				end else if (p == SGR_FAINT || p == SGR_BOLD_OFF) begin
					acc_nxt.bold = FLAG_OFF;
				end else if (p == SGR_UNDER_ON) begin
					acc_nxt.underline = FLAG_ON;
				end else if (p == SGR_UNDER_OFF) begin
					acc_nxt.underline = FLAG_OFF;
				end else if (p == SGR_REVERSE_ON) begin
					acc_nxt.reverse = FLAG_ON;
				end else if (p == SGR_REVERSE_OFF) begin
					acc_nxt.reverse = FLAG_OFF;
				end else if (p >= SGR_FG_BASE && p <= SGR_FG_LAST) begin
					new_col = '{mode: MODE_INDEXED, value: 24'(p - SGR_FG_BASE)};
					set_col = 1'b1;
					set_fg  = 1'b1;
				end else if (p >= SGR_FG_BRIGHT && p <= SGR_FG_BR_LAST) begin
					new_col = '{mode: MODE_INDEXED, value: 24'(p - SGR_FG_BRIGHT + 32'd8)};
					set_col = 1'b1;
					set_fg  = 1'b1;
				end else if (p >= SGR_BG_BASE && p <= SGR_BG_LAST) begin
					new_col = '{mode: MODE_INDEXED, value: 24'(p - SGR_BG_BASE)};
					set_col = 1'b1;
					set_fg  = 1'b0;
				end else if (p >= SGR_BG_BRIGHT && p <= SGR_BG_BR_LAST) begin
					new_col = '{mode: MODE_INDEXED, value: 24'(p - SGR_BG_BRIGHT + 32'd8)};
					set_col = 1'b1;
					set_fg  = 1'b0;
				end else if (p == SGR_FG_EXT || p == SGR_BG_EXT) begin
					acc_nxt.is_fg = (p == SGR_FG_EXT);
					acc_nxt.phase = PH_TYPE;
				end
			end
		endcase
		if (set_col) begin
			if (set_fg) begin
				acc_nxt.fg = new_col;
			end else begin
				acc_nxt.bg = new_col;
			end
		end
	end

	// an empty list overrides everything; otherwise the change after this parameter
	always_comb begin
		if (item_s1.empty_list) begin
			result = ATTR_DEFAULTS;
		end else begin
			result.fg_mode        = acc_nxt.fg.mode;
			result.fg_value       = acc_nxt.fg.value;
			result.bg_mode        = acc_nxt.bg.mode;
			result.bg_value       = acc_nxt.bg.value;
			result.bold_mode      = acc_nxt.bold;
			result.underline_mode = acc_nxt.underline;
			result.reverse_mode   = acc_nxt.reverse;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (param_ready) begin
			valid_s1 <= param_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (param_ready && param_valid) begin
			item_s1 <= param;
		end
	end

	// accumulator: cleared after each sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (advance) begin
			if (emit) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_nxt;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance & emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= result;
		end
	end

	assign attr_valid = out_valid_q;
	assign attr       = out_q;

endmodule

>>> test/sgr_attribute_interpreter_top_tb.sv
`timescale 1ns / 100ps

module sgr_attribute_interpreter_top_tb;
	import sgr_pkg::*;

	// directed row: one parameter item, plus an attribute change typed in by hand
	// where it is obvious (otherwise the predictor supplies it)
	typedef struct packed {
		sgr_in_t  item;
		logic     typed;
		sgr_out_t want;
	} row_t;

	// every attribute back to its default, as code 0 or an empty list gives
	localparam sgr_out_t RESET_ATTR = '{
		fg_mode: MODE_DEFAULT, fg_value: 24'd0,
		bg_mode: MODE_DEFAULT, bg_value: 24'd0,
		bold_mode: FLAG_OFF, underline_mode: FLAG_OFF, reverse_mode: FLAG_OFF
	};
	localparam sgr_out_t FLAGS_ON = '{
		fg_mode: MODE_UNCHANGED, fg_value: 24'd0,
		bg_mode: MODE_UNCHANGED, bg_value: 24'd0,
		bold_mode: FLAG_ON, underline_mode: FLAG_ON, reverse_mode: FLAG_ON
	};
	localparam sgr_out_t PREDICTED = '0;

	localparam int DIRECTED_ROWS = 28;
	localparam int RANDOM_ITEMS  = 1850;

	localparam row_t DIRECTED [DIRECTED_ROWS] = '{
		// empty list with all parameter bits set, not marked last
		'{'{32'hffff_ffff, 1'b0, 1'b1}, 1'b1, RESET_ATTR},
		// lone reset code
		'{'{SGR_RESET, 1'b1, 1'b0}, 1'b1, RESET_ATTR},
		'{'{SGR_BOLD_ON, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{SGR_UNDER_ON, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{SGR_REVERSE_ON, 1'b1, 1'b0}, 1'b1, FLAGS_ON},
		// every off code, then both colour defaults
		'{'{SGR_FAINT, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{SGR_UNDER_OFF, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{SGR_REVERSE_OFF, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{SGR_BOLD_OFF, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{SGR_FG_DEFAULT, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{SGR_BG_DEFAULT, 1'b1, 1'b0}, 1'b1, RESET_ATTR},
		// ends of the base colour ranges, later code wins
		'{'{SGR_FG_BASE, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{SGR_FG_BR_LAST, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{SGR_BG_LAST, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{SGR_BG_BR_LAST, 1'b1, 1'b0}, 1'b0, PREDICTED},
		// 24-bit foreground with wide components
		'{'{SGR_FG_EXT, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{EXT_TYPE_RGB, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{32'hffff_ffff, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{32'h0000_0100, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{32'h0000_00ab, 1'b0, 1'b0}, 1'b0, PREDICTED},
		// palette background at the top of the grey ramp
		'{'{SGR_BG_EXT, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{EXT_TYPE_PALETTE, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{32'hffff_ffff, 1'b0, 1'b0}, 1'b0, PREDICTED},
		// unknown code is ignored
		'{'{32'hffff_ffff, 1'b0, 1'b0}, 1'b0, PREDICTED},
		// unknown extended type swallows itself only
		'{'{SGR_FG_EXT, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{SGR_REVERSE_ON, 1'b0, 1'b0}, 1'b0, PREDICTED},
		// extended colour cut short by the end of the list
		'{'{SGR_BG_EXT, 1'b0, 1'b0}, 1'b0, PREDICTED},
		'{'{EXT_TYPE_RGB, 1'b1, 1'b0}, 1'b0, PREDICTED}
	};

	logic     clk;
	logic     arst_n      = 1'b0;
	logic     param_valid = 1'b0;
	logic     param_ready;
	sgr_in_t  param       = '0;
	logic     attr_valid;
	logic     attr_ready  = 1'b0;
	sgr_out_t attr;

	// attribute change being gathered for the current sequence
	logic [1:0]  cur_fg_mode, cur_bg_mode;
	logic [23:0] cur_fg_value, cur_bg_value;
	logic [1:0]  cur_bold, cur_underline, cur_reverse;
	// extended colour progress
	logic [2:0]  ext_step;
	logic        ext_fg;
	logic [15:0] rg_hold;

	sgr_out_t    pending_attrs[$];
	sgr_in_t     seq_q[$];
	int unsigned mismatches = 0;
	int unsigned useful_sent = 0;
	bit          tx_steady = 0;
	bit          rx_steady = 0;
	int          stall_left = 0;
	sgr_out_t    want_attr;

	sgr_attribute_interpreter_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.param_valid (param_valid),
		.param_ready (param_ready),
		.param       (param),
		.attr_valid  (attr_valid),
		.attr_ready  (attr_ready),
		.attr        (attr)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("[sgr_attribute_interpreter_top] ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// cube levels 00,5f,87,af,d7,ff step by 40 above the first
	function automatic logic [7:0] cube_ramp(input int s);
		return (s == 0) ? 8'h00 : 8'(8'h37 + 40 * s);
	endfunction

	// xterm-256 index: base colours, then 6x6x6 cube, then grey ramp
	function automatic colour_t xterm_colour(input logic [7:0] n);
		int      k;
		logic [7:0] g;
		colour_t c;
		k = int'(n) - int'(PAL_CUBE_FIRST);
		g = 8'(8'h08 + (int'(n) - int'(PAL_GREY_FIRST)) * 10);
		if (n < PAL_CUBE_FIRST) begin
			c.mode  = MODE_INDEXED;
			c.value = {16'd0, n};
		end else if (n >= PAL_GREY_FIRST) begin
			c.mode  = MODE_RGB;
			c.value = {g, g, g};
		end else begin
			c.mode  = MODE_RGB;
			c.value = {cube_ramp(k / 36), cube_ramp((k / 6) % 6), cube_ramp(k % 6)};
		end
		return c;
	endfunction

	task automatic forget_sequence();
		cur_fg_mode   = MODE_UNCHANGED;
		cur_fg_value  = '0;
		cur_bg_mode   = MODE_UNCHANGED;
		cur_bg_value  = '0;
		cur_bold      = FLAG_UNCHANGED;
		cur_underline = FLAG_UNCHANGED;
		cur_reverse   = FLAG_UNCHANGED;
		ext_step      = PH_IDLE;
		ext_fg        = 1'b0;
		rg_hold       = '0;
	endtask

	task automatic put_colour(input logic fg, input logic [1:0] mode, input logic [23:0] value);
		if (fg) begin
			cur_fg_mode  = mode;
			cur_fg_value = value;
		end else begin
			cur_bg_mode  = mode;
			cur_bg_value = value;
		end
	endtask

	// folds one parameter into the gathered change; has_attr marks a finished sequence
	task automatic interpret_param(input sgr_in_t it, output bit has_attr,
			output sgr_out_t attr_out);
		logic [31:0] p;
		colour_t     pc;
		p        = it.param_value;
		has_attr = 0;
		attr_out = '0;
		if (it.empty_list) begin
			// empty list: plain defaults, whatever was half gathered is dropped
			has_attr = 1;
			attr_out = RESET_ATTR;
			forget_sequence();
		end else begin
			case (ext_step)
				PH_TYPE: begin
					if (p == EXT_TYPE_RGB)
						ext_step = PH_RED;
					else if (p == EXT_TYPE_PALETTE)
						ext_step = PH_INDEX;
					else
						ext_step = PH_IDLE;
				end
				PH_RED: begin
					rg_hold  = {p[7:0], 8'h00};
					ext_step = PH_GREEN;
				end
				PH_GREEN: begin
					rg_hold[7:0] = p[7:0];
					ext_step     = PH_BLUE;
				end
				PH_BLUE: begin
					put_colour(ext_fg, MODE_RGB, {rg_hold, p[7:0]});
					ext_step = PH_IDLE;
				end
				PH_INDEX: begin
					pc = xterm_colour(p[7:0]);
					put_colour(ext_fg, pc.mode, pc.value);
					ext_step = PH_IDLE;
				end
				default: begin
					ext_step = PH_IDLE;
					if (p == SGR_RESET) begin
						put_colour(1'b1, MODE_DEFAULT, '0);
						put_colour(1'b0, MODE_DEFAULT, '0);
						cur_bold      = FLAG_OFF;
						cur_underline = FLAG_OFF;
						cur_reverse   = FLAG_OFF;
					end else if (p == SGR_FG_DEFAULT) begin
						put_colour(1'b1, MODE_DEFAULT, '0);
					end else if (p == SGR_BG_DEFAULT) begin
						put_colour(1'b0, MODE_DEFAULT, '0);
					end else if (p == SGR_BOLD_ON) begin
						cur_bold = FLAG_ON;
					end else if (p == SGR_FAINT || p == SGR_BOLD_OFF) begin
						cur_bold = FLAG_OFF;
					end else if (p == SGR_UNDER_ON || p == SGR_UNDER_OFF) begin
						cur_underline = (p == SGR_UNDER_ON) ? FLAG_ON : FLAG_OFF;
					end else if (p == SGR_REVERSE_ON || p == SGR_REVERSE_OFF) begin
						cur_reverse = (p == SGR_REVERSE_ON) ? FLAG_ON : FLAG_OFF;
					end else if (p >= SGR_FG_BASE && p <= SGR_FG_LAST) begin
						put_colour(1'b1, MODE_INDEXED, 24'(p - SGR_FG_BASE));
					end else if (p >= SGR_FG_BRIGHT && p <= SGR_FG_BR_LAST) begin
						put_colour(1'b1, MODE_INDEXED, 24'(p - SGR_FG_BRIGHT + 8));
					end else if (p >= SGR_BG_BASE && p <= SGR_BG_LAST) begin
						put_colour(1'b0, MODE_INDEXED, 24'(p - SGR_BG_BASE));
					end else if (p >= SGR_BG_BRIGHT && p <= SGR_BG_BR_LAST) begin
						put_colour(1'b0, MODE_INDEXED, 24'(p - SGR_BG_BRIGHT + 8));
					end else if (p == SGR_FG_EXT || p == SGR_BG_EXT) begin
						ext_fg   = (p == SGR_FG_EXT);
						ext_step = PH_TYPE;
					end
					// anything else is an unknown code and falls through untouched
				end
			endcase
			if (it.is_last) begin
				has_attr = 1;
				attr_out = '{cur_fg_mode, cur_fg_value, cur_bg_mode, cur_bg_value,
					cur_bold, cur_underline, cur_reverse};
				forget_sequence();
			end
		end
	endtask

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// mostly back to back, sometimes a short gap, now and then a long hole
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// colour component or palette index: usually in byte range, sometimes wide
	function automatic logic [31:0] pick_byte();
		return ($urandom_range(0, 9) < 6) ? 32'($urandom_range(0, 255)) : 32'($urandom());
	endfunction

	function automatic logic [31:0] pick_plain();
		case ($urandom_range(0, 11))
			0:       return SGR_RESET;
			1:       return SGR_BOLD_ON;
			2:       return SGR_FAINT;
			3:       return SGR_BOLD_OFF;
			4:       return SGR_UNDER_ON;
			5:       return SGR_UNDER_OFF;
			6:       return SGR_REVERSE_ON;
			7:       return SGR_REVERSE_OFF;
			8:       return SGR_FG_DEFAULT;
			9:       return SGR_BG_DEFAULT;
			10:      return $urandom_range(0, 1) ? 32'($urandom_range(30, 37))
						: 32'($urandom_range(90, 97));
			default: return $urandom_range(0, 1) ? 32'($urandom_range(40, 47))
						: 32'($urandom_range(100, 107));
		endcase
	endfunction

	task automatic add_param(input logic [31:0] v);
		seq_q.push_back('{param_value: v, is_last: 1'b0, empty_list: 1'b0});
		useful_sent++;
	endtask

	// one sgr sequence: a mix of plain codes, extended colours, empty lists and some noise,
	// now and then cut short mid-way
	task automatic build_sequence();
		int tokens;
		int kind;
		int keep;
		seq_q.delete();
		tokens = $urandom_range(1, 5);
		for (int i = 0; i < tokens; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				add_param(pick_plain());
			end else if (kind < 60) begin
				add_param($urandom_range(0, 1) ? SGR_FG_EXT : SGR_BG_EXT);
				add_param(EXT_TYPE_RGB);
				add_param(pick_byte());
				add_param(pick_byte());
				add_param(pick_byte());
			end else if (kind < 80) begin
				add_param($urandom_range(0, 1) ? SGR_FG_EXT : SGR_BG_EXT);
				add_param(EXT_TYPE_PALETTE);
				add_param(pick_byte());
			end else if (kind < 86) begin
				// type most likely unknown, small values hit the near misses
				add_param($urandom_range(0, 1) ? SGR_FG_EXT : SGR_BG_EXT);
				add_param($urandom_range(0, 1) ? 32'($urandom_range(0, 9)) : 32'($urandom()));
			end else if (kind < 95) begin
				// noise code, not counted; a small value may still be a code the block acts on
				seq_q.push_back('{param_value: $urandom_range(0, 1) ? 32'($urandom())
					: 32'($urandom_range(0, 127)), is_last: 1'b0, empty_list: 1'b0});
			end else begin
				seq_q.push_back('{param_value: $urandom(), is_last: 1'($urandom_range(0, 1)),
					empty_list: 1'b1});
				useful_sent++;
			end
		end
		if ($urandom_range(0, 9) == 0 && seq_q.size() > 1) begin
			keep  = $urandom_range(1, seq_q.size() - 1);
			seq_q = seq_q[0:keep-1];
		end
		seq_q[seq_q.size()-1].is_last = 1'b1;
	endtask

	// hand one item over, then log what it should produce
	task automatic deliver(input sgr_in_t it, input bit typed, input sgr_out_t typed_attr);
		int       gap;
		bit       has_attr;
		sgr_out_t attr_out;
		if ($urandom_range(0, 99) == 0)
			tx_steady = !tx_steady;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			param_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		param       <= it;
		param_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(param_valid && param_ready));
		interpret_param(it, has_attr, attr_out);
		if (has_attr)
			pending_attrs.push_back(typed ? typed_attr : attr_out);
	endtask

	// sender holds off until every outstanding change has come out
	task automatic wait_drained();
		param_valid <= 1'b0;
		@(posedge clk);
		while (pending_attrs.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// sender
	// ---------------------------------------------------------------
	initial begin
		bit paused_mid;
		paused_mid = 0;
		forget_sequence();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; typed rows still run through the predictor to keep it in step
		for (int i = 0; i < DIRECTED_ROWS; i++)
			deliver(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
		wait_drained();

		// random sequences
		while (useful_sent < RANDOM_ITEMS) begin
			build_sequence();
			foreach (seq_q[i])
				deliver(seq_q[i], 1'b0, PREDICTED);
			if (!paused_mid && useful_sent > RANDOM_ITEMS / 2) begin
				paused_mid = 1;
				wait_drained();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[sgr_attribute_interpreter_top] OK");
		else
			$display("[sgr_attribute_interpreter_top] ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// receiver: checks each attribute item and stalls at random
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && attr_valid && attr_ready) begin
			if (pending_attrs.size() == 0) begin
				$display("%0t attribute item with nothing pending: expected none, got %h",
					$time, attr);
				mismatches++;
			end else begin
				want_attr = pending_attrs.pop_front();
				check_field("fg_mode", 24'(want_attr.fg_mode), 24'(attr.fg_mode));
				check_field("fg_value", want_attr.fg_value, attr.fg_value);
				check_field("bg_mode", 24'(want_attr.bg_mode), 24'(attr.bg_mode));
				check_field("bg_value", want_attr.bg_value, attr.bg_value);
				check_field("bold_mode", 24'(want_attr.bold_mode), 24'(attr.bold_mode));
				check_field("underline_mode", 24'(want_attr.underline_mode),
					24'(attr.underline_mode));
				check_field("reverse_mode", 24'(want_attr.reverse_mode),
					24'(attr.reverse_mode));
			end
		end
		// stretches of full throughput alternate with stalls of random length
		if ($urandom_range(0, 299) == 0)
			rx_steady = !rx_steady;
		if (rx_steady) begin
			attr_ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			attr_ready <= 1'b0;
		end else begin
			stall_left = pick_gap();
			attr_ready <= (stall_left == 0);
		end
	end

endmodule

>>> sgr_attribute_interpreter_top.f
rtl/sgr_pkg.sv
rtl/sgr_attribute_interpreter_top.sv
test/sgr_attribute_interpreter_top_tb.sv
